@@ hdl/bba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, command codes and register indexes shared by all files.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int CMD_W      = 2;
  localparam int RUN_W      = 11;
  localparam int ADDR_W     = 32;
  localparam int START_W    = 10;
  localparam int CFG_DATA_W = 32;
  localparam int WORD_BITS  = 32;
  localparam int POS_W      = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_FORCE = 2'd2
  } cmd_t;

  typedef enum logic [0:0] {
    REG_BASE   = 1'b0,
    REG_BLOCKS = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

@@ hdl/bba_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_in_if;
  import bba_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [RUN_W-1:0]   run_length;
  logic [ADDR_W-1:0]  block_address;
  logic [START_W-1:0] start_block;

  modport source (output valid, command, run_length, block_address, start_block,
                  input ready);
  modport sink   (input valid, command, run_length, block_address, start_block,
                  output ready);
endinterface

interface bba_out_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic              success;

  modport source (output valid, result_address, success, input ready);
  modport sink   (input valid, result_address, success, output ready);
endinterface
`default_nettype wire

@@ hdl/bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit run allocation, free by address and forced run allocation over a
// used/free bitmap held in a word-wide synchronous memory.
// ----------------------------------------------------------------------------
// The bitmap holds one bit per block, 32 blocks to a memory word. After reset
// the block runs a clearing pass that writes every word (block 0 is left
// reserved) and accepts no request meanwhile; configuration writes are taken
// at any time. Requests are handled one at a time. An allocate scans the
// words upward, one word per cycle, until a run fits or the last word has been
// scanned, then reads and writes back each word touched by the run to mark it.
// A free marks its one word the same way, a forced run each word it spans.
// The result sits in an output register, so the next request may be
// transferred while an earlier result waits.
// BLOCK_BYTES must be a power of two and MAX_BLOCKS a multiple of 32.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bba_in_if.sink                         in_ch,
  bba_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  bba_pkg::cfg_reg_t              cfg_addr,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  localparam int WORDS  = MAX_BLOCKS / WORD_BITS;
  localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BIW    = WAW + POS_W;
  localparam int RW     = (BIW + 1 > RUN_W) ? BIW + 1 : RUN_W;
  localparam int SW     = RW + 1;
  localparam int LOG_BB = $clog2(BLOCK_BYTES);
  localparam logic [RW-1:0]  MAX_N     = RW'(MAX_BLOCKS);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_SCAN    = 6'b000100,
    ST_MARK_RD = 6'b001000,
    ST_MARK_WR = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    base_r;
  logic [RUN_W-1:0]     nblk_r;
  cmd_t                 cmd_r, cmd_nxt;
  logic [RUN_W-1:0]     len_r, len_nxt;
  logic [ADDR_W-1:0]    addr_r, addr_nxt;
  logic [WAW-1:0]       word_r, word_nxt;
  logic [RW-1:0]        run_r, run_nxt;
  logic [RW-1:0]        lo_r, lo_nxt;
  logic [RW-1:0]        hi_r, hi_nxt;
  logic                 set_r, set_nxt;
  logic                 ok_r, ok_nxt;
  logic [WAW-1:0]       clr_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_addr_r;
  logic                 out_ok_r;

  logic [RW-1:0]        nlim;
  logic                 in_xfer;
  logic                 done_fire;
  logic [ADDR_W-1:0]    off;
  logic [ADDR_W-1:0]    free_b;
  logic                 free_ok;
  logic [SW-1:0]        force_end;
  logic                 force_ok;

  logic                 mem_we;
  logic [WAW-1:0]       mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WAW-1:0]       mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic                 scan_hit;
  logic [POS_W-1:0]     scan_pos;
  logic [RW-1:0]        scan_run;
  logic [RW-1:0]        hit_idx;
  logic [RW-1:0]        first_idx;
  logic [WORD_BITS-1:0] mark_mask;
  logic [63:0]          lo_shift;
  logic [ADDR_W-1:0]    res_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      nblk_r <= RUN_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BASE:   base_r <= cfg_wdata;
        REG_BLOCKS: nblk_r <= cfg_wdata[RUN_W-1:0];
      endcase
    end
  end

  // The effective block count is the configured count capped by the bitmap.
  assign nlim = (RW'(nblk_r) > MAX_N) ? MAX_N : RW'(nblk_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign done_fire   = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // A free must land on a block boundary inside the managed range.
  assign off     = in_ch.block_address - base_r;
  assign free_b  = off >> LOG_BB;
  assign free_ok = (off[LOG_BB-1:0] == '0) && (free_b < ADDR_W'(nlim));

  assign force_end = SW'(in_ch.start_block) + SW'(in_ch.run_length);
  assign force_ok  = (in_ch.run_length != '0) && (RW'(in_ch.start_block) < nlim) &&
                     (force_end <= SW'(nlim));

  bba_run_scan #(
    .WAW (WAW),
    .RW  (RW)
  ) u_scan (
    .word_idx (word_r),
    .word     (mem_rdata),
    .blk_lim  (nlim),
    .run_in   (run_r),
    .len      (RW'(len_r)),
    .hit      (scan_hit),
    .hit_pos  (scan_pos),
    .run_out  (scan_run)
  );

  assign hit_idx   = RW'({word_r, scan_pos});
  assign first_idx = hit_idx + RW'(1) - RW'(len_r);

  // Bits of the current word that fall inside the run being marked.
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      mark_mask[k] = (RW'({word_r, POS_W'(k)}) >= lo_r) &&
                     (RW'({word_r, POS_W'(k)}) <= hi_r);
    end
  end

  // Memory access. Marking reads a word and writes it back in the next cycle
  // before the following word is read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_r;
    mem_wdata = set_r ? (mem_rdata | mark_mask) : (mem_rdata & ~mark_mask);
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = {{(WORD_BITS-1){1'b0}}, (clr_r == '0)};
    end else if (state_r == ST_MARK_WR) begin
      mem_we    = 1'b1;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: mem_raddr = '0;
      ST_SCAN: mem_raddr = word_r + WAW'(1);
      default: mem_raddr = word_r;
    endcase
  end

  bba_bitmap_mem #(
    .DEPTH (WORDS),
    .AW    (WAW)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata),
    .raddr     (mem_raddr),
    .rd_data_r (mem_rdata)
  );

  // Request sequencer.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    addr_nxt  = addr_r;
    word_nxt  = word_r;
    run_nxt   = run_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    set_nxt   = set_r;
    ok_nxt    = ok_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_nxt   = cmd_t'(in_ch.command);
          len_nxt   = in_ch.run_length;
          addr_nxt  = in_ch.block_address;
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
          unique case (in_ch.command)
            CMD_ALLOC: begin
              if (in_ch.run_length != '0 && nlim != '0) begin
                word_nxt  = '0;
                run_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            CMD_FREE: begin
              if (free_ok) begin
                lo_nxt    = RW'(free_b);
                hi_nxt    = RW'(free_b);
                set_nxt   = 1'b0;
                word_nxt  = free_b[BIW-1:POS_W];
                state_nxt = ST_MARK_RD;
              end
            end
            CMD_FORCE: begin
              if (force_ok) begin
                lo_nxt    = RW'(in_ch.start_block);
                hi_nxt    = RW'(force_end - SW'(1));
                set_nxt   = 1'b1;
                word_nxt  = lo_nxt[BIW-1:POS_W];
                state_nxt = ST_MARK_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          lo_nxt    = first_idx;
          hi_nxt    = hit_idx;
          set_nxt   = 1'b1;
          word_nxt  = first_idx[BIW-1:POS_W];
          state_nxt = ST_MARK_RD;
        end else if (word_r == LAST_WORD) begin
          state_nxt = ST_DONE;
        end else begin
          word_nxt = word_r + WAW'(1);
          run_nxt  = scan_run;
        end
      end
      ST_MARK_RD: begin
        state_nxt = ST_MARK_WR;
      end
      ST_MARK_WR: begin
        if (word_r == hi_r[BIW-1:POS_W]) begin
          ok_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          word_nxt  = word_r + WAW'(1);
          state_nxt = ST_MARK_RD;
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result address: a free echoes the request, a run gives its first block.
  assign lo_shift = 64'(lo_r) << LOG_BB;
  always_comb begin
    res_addr = '0;
    if (ok_r) begin
      res_addr = (cmd_r == CMD_FREE) ? addr_r : base_r + lo_shift[ADDR_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ok_r        <= ok_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + WAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    len_r  <= len_nxt;
    addr_r <= addr_nxt;
    word_r <= word_nxt;
    run_r  <= run_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    set_r  <= set_nxt;
    if (done_fire) begin
      out_addr_r <= res_addr;
      out_ok_r   <= ok_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.success        = out_ok_r;

`ifndef SYNTHESIS
  // A refused request always reports address zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.success) |-> (out_ch.result_address == '0))
    else $error("refused result carries a nonzero address");

  // The bitmap is written only by the clearing pass or a mark write-back.
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR || state_r == ST_MARK_WR))
    else $error("bitmap written outside clear or mark");

  // Once a request is transferred no second one is taken until it finishes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in progress");
`endif

endmodule
`default_nettype wire

@@ hdl/bba_bitmap_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_bitmap_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [bba_pkg::WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [bba_pkg::WORD_BITS-1:0] rd_data_r
);
  import bba_pkg::*;

  logic [WORD_BITS-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/bba_run_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free run scanner
// Extends the running count of free blocks across one bitmap word and finds
// the first bit position at which the run reaches the requested length.
// ----------------------------------------------------------------------------
module bba_run_scan #(
  parameter int WAW = 5,
  parameter int RW  = 11
) (
  input  logic [WAW-1:0]                word_idx,
  input  logic [bba_pkg::WORD_BITS-1:0] word,
  input  logic [RW-1:0]                 blk_lim,
  input  logic [RW-1:0]                 run_in,
  input  logic [RW-1:0]                 len,
  output logic                          hit,
  output logic [bba_pkg::POS_W-1:0]     hit_pos,
  output logic [RW-1:0]                 run_out
);
  import bba_pkg::*;

  logic [WORD_BITS-1:0] used;
  logic [WORD_BITS-1:0] hit_k;
  logic [RW-1:0]        run_k [WORD_BITS];

  // Blocks past the managed count behave as used.
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      used[k] = word[k] | (RW'({word_idx, POS_W'(k)}) >= blk_lim);
    end
  end

  always_comb begin
    logic             seen;
    logic [POS_W-1:0] last;
    seen = 1'b0;
    last = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      seen = 1'b0;
      last = '0;
      for (int j = 0; j <= k; j++) begin
        if (used[j]) begin
          seen = 1'b1;
          last = POS_W'(j);
        end
      end
      run_k[k] = seen ? RW'(POS_W'(k) - last) : run_in + RW'(k + 1);
      hit_k[k] = (run_k[k] >= len);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (hit_k[k]) begin
        hit_pos = POS_W'(k);
      end
    end
  end

  assign hit     = |hit_k;
  assign run_out = run_k[WORD_BITS-1];

endmodule
`default_nettype wire
